FILE: rtl/mcpm_pkg.sv
// Package for the command token pattern matcher: payload structs, result codes
// and the fixed table of seventeen left/right pattern pairs.
// No dependencies.
package mcpm_pkg;

	localparam int PATTERN_COUNT = 17;
	localparam int LEFT_MAX      = 4;

	typedef struct packed {
		logic [7:0] char_in;
		logic       last_char;
	} cmd_t;

	typedef struct packed {
		logic       found;
		logic [4:0] pattern_index;
		logic [2:0] handler_class;
		logic [2:0] arg_code;
		logic [7:0] end_offset;
		logic       overflow;
	} res_t;

	typedef enum logic [2:0] {
		HC_COMMA   = 3'd0,
		HC_STOP    = 3'd1,
		HC_CASE    = 3'd2,
		HC_CARRY   = 3'd3,
		HC_GLUE    = 3'd4,
		HC_ATTACH  = 3'd5,
		HC_RESTART = 3'd6
	} hclass_t;

	typedef enum logic [2:0] {
		ARG_ATTACH_LEFT  = 3'd0,
		ARG_CAP_WORD     = 3'd1,
		ARG_LOWER_CHAR   = 3'd2,
		ARG_UPPER_WORD   = 3'd3,
		ARG_ATTACH_RIGHT = 3'd4,
		ARG_BOTH         = 3'd5,
		ARG_CHAR         = 3'd6
	} argc_t;

	// Kind of right string that closes a pattern.
	typedef enum logic [1:0] {
		RIGHT_NONE        = 2'd0,
		RIGHT_BRACE       = 2'd1,
		RIGHT_CARET_BRACE = 2'd2
	} rkind_t;

	typedef struct packed {
		logic [0:LEFT_MAX-1][7:0] left;
		logic [2:0]               left_len;
		rkind_t                   rkind;
		hclass_t                  cls;
		argc_t                    arg;
	} pat_t;

	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// Priority order: lowest index wins.
	localparam pat_t PATTERNS [PATTERN_COUNT] = '{
		'{left: {"{,}", 8'h00}, left_len: 3'd3, rkind: RIGHT_NONE,
			cls: HC_COMMA, arg: ARG_ATTACH_LEFT},
		'{left: {"{:}", 8'h00}, left_len: 3'd3, rkind: RIGHT_NONE,
			cls: HC_COMMA, arg: ARG_ATTACH_LEFT},
		'{left: {"{;}", 8'h00}, left_len: 3'd3, rkind: RIGHT_NONE,
			cls: HC_COMMA, arg: ARG_ATTACH_LEFT},
		'{left: {"{.}", 8'h00}, left_len: 3'd3, rkind: RIGHT_NONE,
			cls: HC_STOP, arg: ARG_ATTACH_LEFT},
		'{left: {"{!}", 8'h00}, left_len: 3'd3, rkind: RIGHT_NONE,
			cls: HC_STOP, arg: ARG_ATTACH_LEFT},
		'{left: {"{?}", 8'h00}, left_len: 3'd3, rkind: RIGHT_NONE,
			cls: HC_STOP, arg: ARG_ATTACH_LEFT},
		'{left: "{-|}", left_len: 3'd4, rkind: RIGHT_NONE,
			cls: HC_CASE, arg: ARG_CAP_WORD},
		'{left: {"{>}", 8'h00}, left_len: 3'd3, rkind: RIGHT_NONE,
			cls: HC_CASE, arg: ARG_LOWER_CHAR},
		'{left: {"{<}", 8'h00}, left_len: 3'd3, rkind: RIGHT_NONE,
			cls: HC_CASE, arg: ARG_UPPER_WORD},
		'{left: "{^~|", left_len: 3'd4, rkind: RIGHT_BRACE,
			cls: HC_CARRY, arg: ARG_UPPER_WORD},
		'{left: {"{~|", 8'h00}, left_len: 3'd3, rkind: RIGHT_BRACE,
			cls: HC_CARRY, arg: ARG_UPPER_WORD},
		'{left: {"{&", 16'h0000}, left_len: 3'd2, rkind: RIGHT_BRACE,
			cls: HC_GLUE, arg: ARG_ATTACH_LEFT},
		'{left: {"{^}", 8'h00}, left_len: 3'd3, rkind: RIGHT_NONE,
			cls: HC_ATTACH, arg: ARG_ATTACH_RIGHT},
		'{left: {"{^", 16'h0000}, left_len: 3'd2, rkind: RIGHT_CARET_BRACE,
			cls: HC_ATTACH, arg: ARG_BOTH},
		'{left: {"{^", 16'h0000}, left_len: 3'd2, rkind: RIGHT_BRACE,
			cls: HC_ATTACH, arg: ARG_ATTACH_LEFT},
		'{left: {"{}", 16'h0000}, left_len: 3'd2, rkind: RIGHT_NONE,
			cls: HC_RESTART, arg: ARG_CHAR},
		'{left: {"{", 24'h000000}, left_len: 3'd1, rkind: RIGHT_CARET_BRACE,
			cls: HC_ATTACH, arg: ARG_ATTACH_RIGHT}
	};

endpackage

FILE: rtl/meta_command_pattern_matcher_unit.sv
// Command token pattern matcher, top level.
// Depends on mcpm_pkg for payload structs and the pattern table.

// A token arrives one byte per request on the cmd channel, the final byte
// flagged by last_char. Each byte is captured in an input register, then one
// stage of parallel comparators updates a left-prefix flag, a right-string
// flag and a right-string offset for each of the seventeen patterns. On the
// final byte a priority encoder picks the lowest-numbered matching pattern and
// the result is loaded from the input register's byte into the output
// register; the per-token state then returns to its reset values, so the next
// token may follow directly. Bytes are taken back to back at one per cycle;
// the flow stalls only while a finished result sits unread in the output
// register and another final byte wants it. Tokens longer than MAX_LEN bytes
// report overflow with no match, and offsets above 255 read as 255.
module meta_command_pattern_matcher_unit
	import mcpm_pkg::*;
#(
	parameter int MAX_LEN = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	// Position counts up to MAX_LEN + 1 and then holds.
	localparam int PW = $clog2(MAX_LEN + 2);
	localparam logic [PW-1:0] POS_MAX = PW'(MAX_LEN);

	// Input register
	logic       s1_valid;
	cmd_t       cmd_s1;
	logic       s1_fire;

	// Per-token state
	logic [PW-1:0]            position_q;
	logic [7:0]               prev_char_q;
	logic [PATTERN_COUNT-1:0] left_ok_q;
	logic [PATTERN_COUNT-1:0] right_seen_q;
	logic [7:0]               right_off_q [PATTERN_COUNT];

	// Next-state values
	logic [PW-1:0]            position_d;
	logic [PATTERN_COUNT-1:0] left_ok_d;
	logic [PATTERN_COUNT-1:0] right_seen_d;
	logic [7:0]               right_off_d [PATTERN_COUNT];

	logic [PW+7:0]            pos_ext;
	logic [PW+7:0]            pos_m1_ext;
	logic [7:0]               pos_sat;
	logic [7:0]               pos_m1_sat;
	logic [PATTERN_COUNT-1:0] hit;
	logic                     over;
	res_t                     res_d;

	res_t res_q;
	logic res_valid_q;

	// Hold the input register while a final byte waits for the output register.
	assign s1_fire   = s1_valid && (!cmd_s1.last_char || !res_valid_q || res_ready);
	assign cmd_ready = !s1_valid || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (cmd_ready) begin
			s1_valid <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_s1 <= cmd;
		end
	end

	// Saturated copies of the current offset and the one before it.
	assign pos_ext    = (PW+8)'(position_q);
	assign pos_m1_ext = pos_ext - (PW+8)'(1);
	assign pos_sat    = (pos_ext > (PW+8)'(255)) ? 8'hFF : pos_ext[7:0];
	assign pos_m1_sat = (pos_m1_ext > (PW+8)'(255)) ? 8'hFF : pos_m1_ext[7:0];

	assign position_d = (position_q <= POS_MAX) ? position_q + PW'(1) : position_q;
	assign over       = position_d > POS_MAX;

	// Update each pattern's flags from the current byte.
	always_comb begin
		for (int i = 0; i < PATTERN_COUNT; i++) begin
			left_ok_d[i]    = left_ok_q[i];
			right_seen_d[i] = right_seen_q[i];
			right_off_d[i]  = right_off_q[i];
			if (position_q < PW'(PATTERNS[i].left_len)) begin
				if (PATTERNS[i].left[position_q[1:0]] != cmd_s1.char_in) begin
					left_ok_d[i] = 1'b0;
				end
			end else if (left_ok_q[i] && !right_seen_q[i]) begin
				if (PATTERNS[i].rkind == RIGHT_BRACE && cmd_s1.char_in == CH_RBRACE) begin
					right_seen_d[i] = 1'b1;
					right_off_d[i]  = pos_sat;
				end else if (PATTERNS[i].rkind == RIGHT_CARET_BRACE
						&& position_q >= PW'(PATTERNS[i].left_len) + PW'(1)
						&& prev_char_q == CH_CARET && cmd_s1.char_in == CH_RBRACE) begin
					right_seen_d[i] = 1'b1;
					right_off_d[i]  = pos_m1_sat;
				end
			end
		end
	end

	// Match vector and priority pick; the lowest index wins.
	always_comb begin
		for (int i = 0; i < PATTERN_COUNT; i++) begin
			hit[i] = left_ok_d[i] && (position_d >= PW'(PATTERNS[i].left_len))
				&& (PATTERNS[i].rkind == RIGHT_NONE || right_seen_d[i]);
		end
		res_d          = '0;
		res_d.overflow = over;
		if (!over) begin
			for (int i = PATTERN_COUNT - 1; i >= 0; i--) begin
				if (hit[i]) begin
					res_d.found         = 1'b1;
					res_d.pattern_index = 5'(i);
					res_d.handler_class = PATTERNS[i].cls;
					res_d.arg_code      = PATTERNS[i].arg;
					res_d.end_offset    = (PATTERNS[i].rkind == RIGHT_NONE)
						? 8'(PATTERNS[i].left_len) : right_off_d[i];
				end
			end
		end
	end

	// Advance the token state; drop it back to reset after the final byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q   <= '0;
			prev_char_q  <= '0;
			left_ok_q    <= '1;
			right_seen_q <= '0;
		end else if (s1_fire) begin
			if (cmd_s1.last_char) begin
				position_q   <= '0;
				prev_char_q  <= '0;
				left_ok_q    <= '1;
				right_seen_q <= '0;
			end else begin
				position_q   <= position_d;
				prev_char_q  <= cmd_s1.char_in;
				left_ok_q    <= left_ok_d;
				right_seen_q <= right_seen_d;
			end
		end
	end

	// Offsets are read only behind their right_seen bit.
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			for (int i = 0; i < PATTERN_COUNT; i++) begin
				right_off_q[i] <= right_off_d[i];
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_fire && cmd_s1.last_char) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && cmd_s1.last_char) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
